@@ hw/rtl/sacl_pkg.sv @@
// Shared constants for the set-associative cache LRU lookup unit.
package sacl_pkg;

  localparam int TAG_W          = 64;
  localparam int ADDR_W         = 64;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_MAX_SETS   = 64;

  localparam int OFFSET_BITS_W  = 5;
  localparam int INDEX_BITS_W   = 3;
  localparam int FIELD_W        = 7;
  localparam int SHIFT_W        = 6;
  localparam int WAY_OUT_W      = 2;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RST  = 3'd2;

endpackage

@@ hw/rtl/sacl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/set_assoc_cache_lru_lookup_unit.sv @@
// Set-associative cache tag lookup with LRU replacement.
// Result: the accepting edge enters S_LOOK, whose lookup result is registered onto out_valid.
// Requests: busy stays high through S_LOOK, so no new one is taken before the set row read on accept is written back.
// After reset a clearing pass initialises every row of the set memory; busy
// stays high meanwhile. Configuration writes are taken at any time.
// The receiver cannot stall; each result is shown for one cycle on out_valid.
module set_assoc_cache_lru_lookup_unit
  import sacl_pkg::*;
#(
  parameter int WAYS     = DEF_WAYS,
  parameter int MAX_SETS = DEF_MAX_SETS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADDR_W-1:0]        in_address,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic                     out_miss,
  output logic                     out_evicted,
  output logic [WAY_OUT_W-1:0]     out_way_used,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = 1 + WAY_W + TAG_W;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam int LUT_N   = 1 << FIELD_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);
  localparam logic [WAY_W-1:0] LRU_RANK = WAY_W'(WAYS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SET_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0]         set_r, set_nxt;
  logic [TAG_W-1:0]         tag_r, tag_nxt;
  logic [OFFSET_BITS_W-1:0] offset_bits_r, offset_bits_nxt;
  logic [INDEX_BITS_W-1:0]  index_bits_r, index_bits_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r, out_hit_nxt;
  logic                     out_miss_r, out_miss_nxt;
  logic                     out_evicted_r, out_evicted_nxt;
  logic [WAY_OUT_W-1:0]     out_way_r, out_way_nxt;

  logic [SET_W-1:0]         set_lut [LUT_N];
  logic [ADDR_W-1:0]        addr_shift;
  logic [FIELD_W-1:0]       field_mask;
  logic [FIELD_W-1:0]       field;
  logic [SET_W-1:0]         set_in;
  logic [TAG_W-1:0]         tag_in;

  logic                     ram_we;
  logic [SET_W-1:0]         ram_waddr;
  logic [ROW_W-1:0]         ram_wdata;
  logic [ROW_W-1:0]         ram_rdata;
  logic [ROW_W-1:0]         clr_row;
  logic [ROW_W-1:0]         upd_row;

  logic                     ln_valid [WAYS];
  logic [WAY_W-1:0]         ln_rank  [WAYS];
  logic [TAG_W-1:0]         ln_tag   [WAYS];
  logic                     hit_found, free_found, lru_found;
  logic [WAY_W-1:0]         hit_way, free_way, lru_way, sel_way;
  logic [WAY_W-1:0]         old_rank;
  logic                     accept;

  genvar g;
  generate
    for (g = 0; g < LUT_N; g++) begin : g_set_lut
      assign set_lut[g] = SET_W'(g % MAX_SETS);
    end
  endgenerate

  // set index and tag of the incoming address
  always_comb begin
    addr_shift = in_address >> offset_bits_r;
    field_mask = FIELD_W'((8'd1 << index_bits_r) - 8'd1);
    field      = addr_shift[FIELD_W-1:0] & field_mask;
    set_in     = set_lut[field];
    tag_in     = in_address >> (SHIFT_W'(offset_bits_r) + SHIFT_W'(index_bits_r));
  end

  // way search and rank update on the row read back
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    lru_found  = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    lru_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      ln_tag[w]   = ram_rdata[w*ENTRY_W +: TAG_W];
      ln_rank[w]  = ram_rdata[w*ENTRY_W + TAG_W +: WAY_W];
      ln_valid[w] = ram_rdata[w*ENTRY_W + TAG_W + WAY_W];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_found && ln_valid[w] && (ln_tag[w] == tag_r)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!free_found && !ln_valid[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (!lru_found && (ln_rank[w] == LRU_RANK)) begin
        lru_found = 1'b1;
        lru_way   = WAY_W'(w);
      end
    end
    sel_way  = hit_found ? hit_way : (free_found ? free_way : lru_way);
    old_rank = ln_rank[sel_way];
    for (int w = 0; w < WAYS; w++) begin
      upd_row[w*ENTRY_W +: TAG_W] = ln_tag[w];
      upd_row[w*ENTRY_W + TAG_W + WAY_W] = ln_valid[w];
      if (WAY_W'(w) == sel_way) begin
        upd_row[w*ENTRY_W + TAG_W +: WAY_W] = '0;
        if (!hit_found) begin
          upd_row[w*ENTRY_W +: TAG_W] = tag_r;
          upd_row[w*ENTRY_W + TAG_W + WAY_W] = 1'b1;
        end
      end else if (ln_rank[w] < old_rank) begin
        upd_row[w*ENTRY_W + TAG_W +: WAY_W] = ln_rank[w] + WAY_W'(1);
      end else begin
        upd_row[w*ENTRY_W + TAG_W +: WAY_W] = ln_rank[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*ENTRY_W +: ENTRY_W] = {1'b0, WAY_W'(w), {TAG_W{1'b0}}};
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_LOOK);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : set_r;
  assign ram_wdata = (state_r == S_CLEAR) ? clr_row : upd_row;

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    set_nxt         = set_r;
    tag_nxt         = tag_r;
    offset_bits_nxt = offset_bits_r;
    index_bits_nxt  = index_bits_r;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_miss_nxt    = out_miss_r;
    out_evicted_nxt = out_evicted_r;
    out_way_nxt     = out_way_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits_nxt = cfg_data[OFFSET_BITS_W-1:0];
        REG_INDEX_BITS:  index_bits_nxt  = cfg_data[INDEX_BITS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == LAST_SET) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          set_nxt   = set_in;
          tag_nxt   = tag_in;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        out_valid_nxt   = 1'b1;
        out_hit_nxt     = hit_found;
        out_miss_nxt    = !hit_found;
        out_evicted_nxt = !hit_found && !free_found;
        out_way_nxt     = WAY_OUT_W'(sel_way);
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      offset_bits_r <= OFFSET_BITS_RST;
      index_bits_r  <= INDEX_BITS_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      offset_bits_r <= offset_bits_nxt;
      index_bits_r  <= index_bits_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    set_r         <= set_nxt;
    tag_r         <= tag_nxt;
    out_hit_r     <= out_hit_nxt;
    out_miss_r    <= out_miss_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_way_r     <= out_way_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_miss     = out_miss_r;
  assign out_evicted  = out_evicted_r;
  assign out_way_used = out_way_r;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

endmodule
